/* sv/oaht_pkg.sv */
`default_nettype none
package oaht_pkg;
    localparam int Capacity = 64;
    localparam int IdxW = $clog2(Capacity);
    localparam int CntW = 17;
    localparam int ProbeW = $clog2(Capacity + 1);
    localparam logic [CntW-1:0] MaxEntriesReset = CntW'(48);

    localparam logic [1:0] CMD_SET = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic signed [31:0] key;
        logic [31:0] data_in;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [31:0] data_out;
        logic [CntW-1:0] entry_total;
    } t_rsp;

    function automatic logic [IdxW-1:0] next_slot(input logic [IdxW-1:0] idx);
        logic [IdxW+2:0] prod;
        prod = ({3'b000, idx} << 2) + {3'b000, idx} + (IdxW+3)'(1);
        return prod[IdxW-1:0];
    endfunction
endpackage
`default_nettype wire

/* sv/oaht_front.sv */
`default_nettype none
// Two-entry request queue between the handshake and the probe engine.
module oaht_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire oaht_pkg::t_req  i_req,
    output logic                 o_q_valid,
    output oaht_pkg::t_req       o_q_req,
    input  wire logic            i_q_pop
);
    import oaht_pkg::*;

    t_req r_buf [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push;

    assign o_ready = (r_cnt != 2'd2);
    assign push = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_req = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end
endmodule
`default_nettype wire

/* sv/oaht_engine.sv */
`default_nettype none
module oaht_engine (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [oaht_pkg::CntW-1:0]  i_max_entries,
    input  wire logic                       i_q_valid,
    input  wire oaht_pkg::t_req             i_q_req,
    output logic                            o_q_pop,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output oaht_pkg::t_rsp                  o_rsp
);
    import oaht_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_CHECK, S_OUT} t_state;

    t_state r_state;
    t_req r_req;
    logic [31:0] r_keys [Capacity];
    logic [31:0] r_data [Capacity];
    logic [Capacity-1:0] r_occ, r_tomb;
    logic [CntW-1:0] r_count;
    logic [IdxW-1:0] r_idx, r_tslot;
    logic r_have_tomb;
    logic [ProbeW-1:0] r_n;
    logic [31:0] r_rkey, r_rdata;
    logic r_rocc, r_rtomb;
    t_rsp r_res;
    t_rsp r_rsp;
    logic r_valid;

    logic hit, is_empty, last, over, done;
    logic eff_have_tomb, do_insert;
    logic [IdxW-1:0] free_slot;
    logic [1:0] chk_status;
    logic [31:0] chk_data;
    logic [CntW-1:0] chk_total;

    assign hit = r_rocc && (r_rkey == r_req.key);
    assign is_empty = !r_rocc && !r_rtomb;
    assign last = (r_n == ProbeW'(Capacity - 1));
    assign over = ({1'b0, r_count} + (CntW+1)'(1)) > {1'b0, i_max_entries};
    assign done = hit || is_empty || last;
    // a tombstone met on this probe counts as the first one if none came before
    assign eff_have_tomb = r_have_tomb || (!r_rocc && r_rtomb);
    assign free_slot = r_have_tomb ? r_tslot : r_idx;

    always_comb begin
        do_insert = 1'b0;
        chk_status = ST_ABSENT;
        chk_data = 32'd0;
        chk_total = r_count;
        if (r_req.cmd == CMD_SET) begin
            if (hit) begin
                chk_status = ST_DONE;
            end else if (over || !(eff_have_tomb || is_empty)) begin
                chk_status = ST_FULL;
            end else begin
                do_insert = 1'b1;
                chk_status = ST_DONE;
                chk_total = r_count + CntW'(1);
            end
        end else if (hit) begin
            chk_status = ST_DONE;
            if (r_req.cmd == CMD_REMOVE) begin
                if (r_count != '0) begin
                    chk_total = r_count - CntW'(1);
                end
            end else begin
                chk_data = r_rdata;
            end
        end
    end

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign o_valid = r_valid;
    assign o_rsp = r_rsp;

    always_ff @(posedge i_clk) begin
        r_rkey <= r_keys[r_idx];
        r_rdata <= r_data[r_idx];
        r_rocc <= r_occ[r_idx];
        r_rtomb <= r_tomb[r_idx];
        if (r_state == S_CHECK && r_req.cmd == CMD_SET) begin
            if (hit) begin
                r_data[r_idx] <= r_req.data_in;
            end else if (done && do_insert) begin
                r_keys[free_slot] <= r_req.key;
                r_data[free_slot] <= r_req.data_in;
            end
        end
        if (r_state == S_IDLE && i_q_valid) begin
            r_req <= i_q_req;
        end
        if (r_state == S_OUT && (!r_valid || i_ready)) begin
            r_rsp <= r_res;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ <= '0;
            r_tomb <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
            r_idx <= '0;
            r_n <= '0;
            r_have_tomb <= 1'b0;
            r_tslot <= '0;
        end else begin
            if (r_valid && i_ready && r_state != S_OUT) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_idx <= i_q_req.key[IdxW-1:0];
                        r_n <= '0;
                        r_have_tomb <= 1'b0;
                        // get on empty table answers without probing
                        if (i_q_req.cmd != CMD_SET && i_q_req.cmd != CMD_REMOVE
                                && r_count == '0) begin
                            r_res <= '{ST_ABSENT, 32'd0, r_count};
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: r_state <= S_CHECK;
                S_CHECK: begin
                    if (!r_rocc && r_rtomb && !r_have_tomb) begin
                        r_have_tomb <= 1'b1;
                        r_tslot <= r_idx;
                    end
                    if (done) begin
                        r_state <= S_OUT;
                        r_res <= '{chk_status, chk_data, chk_total};
                        r_count <= chk_total;
                        if (do_insert) begin
                            r_occ[free_slot] <= 1'b1;
                            r_tomb[free_slot] <= 1'b0;
                        end else if (r_req.cmd == CMD_REMOVE && hit) begin
                            r_occ[r_idx] <= 1'b0;
                            r_tomb[r_idx] <= 1'b1;
                        end
                    end else begin
                        r_idx <= next_slot(r_idx);
                        r_n <= r_n + ProbeW'(1);
                        r_state <= S_READ;
                    end
                end
                S_OUT: begin
                    // hold until the output register frees
                    if (!r_valid || i_ready) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* sv/open_address_hash_table_unit.sv */
`default_nettype none
// Open-addressing key/value table, 64 slots, integer keys hashed by their low bits.
// Input channel (i_valid/o_ready, i_req): cmd set, remove or get, key, data_in.
// Output channel (o_valid/i_ready, o_rsp): status, data_out, entry_total; one
// result per request, in request order.
// A two-entry queue takes requests while the probe engine works. The engine
// reads one slot per probe in two states, a memory read (S_READ) and then a
// compare (S_CHECK). It takes a request from the queue in S_IDLE, skips the
// probe states for a get on an empty table, and loads the output register in
// S_OUT; it holds each request until its result is loaded there, so the next
// request leaves the queue only after that. The worst case is 64 probes.
// i_max_entries_we writes the load limit (reset 48); the user must write it
// only while the block is idle, which the block itself does not enforce.
// Reset empties the table at once (no clearing pass). When the receiver stalls
// the result waits in the output register, the engine holds the next result,
// and the queue keeps accepting until full.
module open_address_hash_table_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire oaht_pkg::t_req             i_req,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output oaht_pkg::t_rsp                  o_rsp,
    input  wire logic                       i_max_entries_we,
    input  wire logic [oaht_pkg::CntW-1:0]  i_max_entries
);
    import oaht_pkg::*;

    logic [CntW-1:0] r_max;
    logic q_valid, q_pop;
    t_req q_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MaxEntriesReset;
        end else if (i_max_entries_we) begin
            r_max <= i_max_entries;
        end
    end

    oaht_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_req,
        .o_q_valid(q_valid), .o_q_req(q_req), .i_q_pop(q_pop)
    );

    oaht_engine u_engine (
        .i_clk, .i_rst_n, .i_max_entries(r_max),
        .i_q_valid(q_valid), .i_q_req(q_req), .o_q_pop(q_pop),
        .o_valid, .i_ready, .o_rsp
    );
endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import oaht_pkg::*;

    localparam logic [1:0] CMD_GET = 2'd2;
    localparam logic [1:0] CMD_GET_ALT = 2'd3;
    localparam int IdleLimit = 20000;
    localparam int DrainCycles = 200;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_req i_req;
    logic o_valid;
    logic i_ready;
    t_rsp o_rsp;
    logic i_max_entries_we;
    logic [CntW-1:0] i_max_entries;

    open_address_hash_table_unit u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_req(i_req),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_rsp(o_rsp),
        .i_max_entries_we(i_max_entries_we),
        .i_max_entries(i_max_entries)
    );

    // table shadow
    logic [31:0] key_shadow [Capacity];
    logic [31:0] data_shadow [Capacity];
    logic occ_shadow [Capacity];
    logic tomb_shadow [Capacity];
    logic [CntW-1:0] count_shadow;
    logic [CntW-1:0] limit_shadow;

    t_rsp pending_rsp[$];
    int mismatch_count;
    int quiet_cycles;
    bit stall_enable;
    bit watchdog_fired;
    int rsp_seen;
    logic [31:0] recent_keys[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Walk the probe chain; return hit flag, hit slot, free slot and its presence.
    function automatic void probe_table(input logic [31:0] k, output bit hit,
                                        output int hit_slot, output int free_slot,
                                        output bit have_free);
        logic [IdxW-1:0] idx;
        bit have_tomb;
        int tomb;
        hit = 0;
        hit_slot = 0;
        have_tomb = 0;
        tomb = 0;
        free_slot = 0;
        have_free = 0;
        idx = k[IdxW-1:0];
        for (int n = 0; n < Capacity; n++) begin
            if (!occ_shadow[idx]) begin
                if (!tomb_shadow[idx]) begin
                    free_slot = have_tomb ? tomb : int'(idx);
                    have_free = 1;
                    return;
                end
                if (!have_tomb) begin
                    have_tomb = 1;
                    tomb = int'(idx);
                end
            end else if (key_shadow[idx] == k) begin
                hit = 1;
                hit_slot = int'(idx);
                return;
            end
            idx = IdxW'(idx * 5 + 1);
        end
        free_slot = tomb;
        have_free = have_tomb;
    endfunction

    function automatic t_rsp predict_table(input t_req rq);
        t_rsp r;
        bit hit, have_free;
        int hs, fs;
        r.status = ST_ABSENT;
        r.data_out = '0;
        if (rq.cmd == CMD_SET) begin
            probe_table(rq.key, hit, hs, fs, have_free);
            if (hit) begin
                data_shadow[hs] = rq.data_in;
                r.status = ST_DONE;
            end else if (count_shadow + 1 > limit_shadow || !have_free) begin
                r.status = ST_FULL;
            end else begin
                key_shadow[fs] = rq.key;
                data_shadow[fs] = rq.data_in;
                occ_shadow[fs] = 1'b1;
                tomb_shadow[fs] = 1'b0;
                count_shadow = count_shadow + 1;
                r.status = ST_DONE;
            end
        end else if (rq.cmd == CMD_REMOVE) begin
            probe_table(rq.key, hit, hs, fs, have_free);
            if (hit) begin
                occ_shadow[hs] = 1'b0;
                tomb_shadow[hs] = 1'b1;
                if (count_shadow > 0) count_shadow = count_shadow - 1;
                r.status = ST_DONE;
            end
        end else if (count_shadow != 0) begin
            probe_table(rq.key, hit, hs, fs, have_free);
            if (hit) begin
                r.data_out = data_shadow[hs];
                r.status = ST_DONE;
            end
        end
        r.entry_total = count_shadow;
        return r;
    endfunction

    // Output side: random stall, compare against oldest expectation.
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                rsp_seen <= rsp_seen + 1;
                if (pending_rsp.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: unexpected response %p", o_rsp);
                end else begin
                    exp_rsp = pending_rsp.pop_front();
                    if (o_rsp.status !== exp_rsp.status ||
                        o_rsp.data_out !== exp_rsp.data_out ||
                        o_rsp.entry_total !== exp_rsp.entry_total) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"ERROR: expected st=%0d data=%h total=%0d ",
                                      "got st=%0d data=%h total=%0d"},
                                     exp_rsp.status, exp_rsp.data_out,
                                     exp_rsp.entry_total, o_rsp.status,
                                     o_rsp.data_out, o_rsp.entry_total);
                    end
                end
            end
            i_ready <= stall_enable ? ($urandom_range(99) >= 30) : 1'b1;
        end
    end

    // Watchdog: cycles without any accepted request or response.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IdleLimit && !watchdog_fired) begin
                watchdog_fired <= 1'b1;
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Leaves i_valid high after acceptance; a drain drops it, the next call may drop it or send its own request.
    task automatic send_request(input logic [1:0] cmd, input logic [31:0] k,
                                input logic [31:0] d);
        t_req rq;
        rq.cmd = cmd;
        rq.key = k;
        rq.data_in = d;
        if (stall_enable && $urandom_range(99) < 30) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 30) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_rsp.push_back(predict_table(rq));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CntW-1:0] v);
        i_max_entries_we <= 1'b1;
        i_max_entries <= v;
        @(posedge i_clk);
        i_max_entries_we <= 1'b0;
        limit_shadow = v;
    endtask

    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55 && recent_keys.size() > 0)
            return recent_keys[$urandom_range(recent_keys.size() - 1)];
        if (sel < 80)
            return {2'($urandom_range(3)), 22'h0, 2'b0, 6'($urandom_range(63))} ^
                   (($urandom_range(1) == 1) ? 32'h8000_0000 : 32'h0);
        return $urandom;
    endfunction

    task automatic random_ops(input int count);
        logic [1:0] cmd;
        logic [31:0] k;
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            cmd = (sel < 45) ? CMD_SET : (sel < 70) ? CMD_REMOVE :
                  (sel < 95) ? CMD_GET : CMD_GET_ALT;
            k = pick_key();
            if (cmd == CMD_SET) begin
                recent_keys.push_back(k);
                if (recent_keys.size() > 80) void'(recent_keys.pop_front());
            end
            send_request(cmd, k, $urandom);
        end
    endtask

    task automatic test_directed();
        send_request(CMD_GET, 32'h0, 32'h0);            // get on empty table
        send_request(CMD_REMOVE, 32'h5, 32'h0);         // remove absent
        send_request(CMD_SET, 32'h0, 32'hFFFF_FFFF);
        send_request(CMD_SET, 32'h8000_0000, 32'h1234_5678); // same home slot
        send_request(CMD_SET, 32'h7FFF_FFFF, 32'hA5A5_A5A5);
        send_request(CMD_SET, 32'hFFFF_FFFF, 32'h0);
        send_request(CMD_GET, 32'h8000_0000, 32'h0);
        send_request(CMD_GET_ALT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_SET, 32'h0, 32'h5A5A_5A5A);     // update in place
        send_request(CMD_REMOVE, 32'h0, 32'h0);          // leave tombstone
        send_request(CMD_GET, 32'h8000_0000, 32'h0);     // probe past tombstone
        send_request(CMD_SET, 32'h40, 32'h1111_1111);    // reuse tombstone
        send_request(CMD_GET, 32'h40, 32'h0);
        send_request(CMD_GET, 32'h0, 32'h0);
        send_request(CMD_REMOVE, 32'h7FFF_FFFF, 32'h0);
        send_request(CMD_REMOVE, 32'h7FFF_FFFF, 32'h0);
        wait_drained();
    endtask

    task automatic test_limit_extremes();
        write_limit(CntW'(1));
        send_request(CMD_SET, 32'h3, 32'h1);            // full: new key over limit
        send_request(CMD_SET, 32'h8000_0000, 32'h2);     // update while over limit
        wait_drained();
        write_limit(CntW'(4));
        random_ops(200);
        wait_drained();
        write_limit(CntW'(65536));
        // fill every slot, then force a set with no free slot
        for (int n = 0; n < Capacity + 4; n++)
            send_request(CMD_SET, 32'(n) + 32'h100, 32'(n));
        wait_drained();
        for (int n = 0; n < 8; n++)
            send_request(CMD_REMOVE, 32'(n * 3) + 32'h100, 32'h0);
        random_ops(150);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        write_limit(CntW'(48));
        stall_enable = 1'b0;
        random_ops(300);
        stall_enable = 1'b1;
        random_ops(500);
        wait_drained();
        write_limit(CntW'(20));
        random_ops(400);
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        i_max_entries_we = 1'b0;
        i_max_entries = '0;
        mismatch_count = 0;
        rsp_seen = 0;
        watchdog_fired = 1'b0;
        stall_enable = 1'b1;
        count_shadow = '0;
        limit_shadow = MaxEntriesReset;
        for (int n = 0; n < Capacity; n++) begin
            key_shadow[n] = '0;
            data_shadow[n] = '0;
            occ_shadow[n] = 1'b0;
            tomb_shadow[n] = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_limit_extremes();
        test_random_traffic();

        if (mismatch_count == 0 && pending_rsp.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

/* open_address_hash_table_unit.f */
sv/oaht_pkg.sv
sv/oaht_front.sv
sv/oaht_engine.sv
sv/open_address_hash_table_unit.sv
bench/tb.sv
